>>> rtl/pal_pkg.sv
// Package for the positional array list: field widths, command and status codes.
// No dependencies; imported by positional_array_list_top.
package pal_pkg;

  localparam int CMD_W = 3;
  localparam int POS_W = 5;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int OUT_W = 5;   // width of found_position and count results

  typedef logic [CMD_W-1:0] cmd_t;
  typedef logic [ST_W-1:0]  status_t;
  typedef logic [VAL_W-1:0] val_t;

  localparam cmd_t CMD_CLEAR    = 3'd0;
  localparam cmd_t CMD_INSERT   = 3'd1;
  localparam cmd_t CMD_DELETE   = 3'd2;
  localparam cmd_t CMD_LOCATE   = 3'd3;
  localparam cmd_t CMD_RETRIEVE = 3'd4;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_FULL   = 2'd1;
  localparam status_t ST_BADPOS = 2'd2;
  localparam status_t ST_EMPTY  = 2'd3;

endpackage

>>> rtl/positional_array_list_top.sv
// Positional array list: bounded ordered list in a single-port-write, one-read RAM.
// Depends on pal_pkg (field widths, command and status codes).
//
// Sequence of an item: clear, rejected commands and unknown codes are answered straight
//   from idle; retrieve issues a single read; insert and delete walk the m elements to move
//   (count-position+1 for insert, count-position for delete), then insert writes the new
//   element; locate reads from position 1 until a hit or the end of the list.
//   The element walk through the RAM does one read per cycle, and one write in shifts.
// Throughput: one item at a time; a new item may be taken in the cycle its predecessor's
//   result is shown. Results cannot be stalled and appear for one cycle on out_valid.
// Reset (rst_n, synchronous, active low) empties the list; the RAM is not cleared.
module positional_array_list_top #(
  parameter int CAPACITY = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [pal_pkg::CMD_W-1:0]   in_cmd,
  input  logic [pal_pkg::POS_W-1:0]   in_position,
  input  logic signed [pal_pkg::VAL_W-1:0] in_value,
  output logic                        out_valid,
  output logic [pal_pkg::ST_W-1:0]    out_status,
  output logic [pal_pkg::OUT_W-1:0]   out_found_position,
  output logic signed [pal_pkg::VAL_W-1:0] out_read_value,
  output logic [pal_pkg::OUT_W-1:0]   out_count
);
  import pal_pkg::*;

  // AW indexes the RAM, CW holds a count 0..CAPACITY, LW is wide enough to compare
  // a count against a 5-bit position and to form count+1 without overflow.
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = ((CW > POS_W) ? CW : POS_W) + 1;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;  // shift up, then write the new element
  localparam logic [2:0] S_DEL  = 3'd2;  // shift down
  localparam logic [2:0] S_LOC  = 3'd3;  // linear search
  localparam logic [2:0] S_RET  = 3'd4;  // single read

  // Element store: one write port, one registered read port.
  val_t          mem [CAPACITY];
  val_t          rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  val_t          mem_wd;
  logic          mem_re;

  logic [2:0]    state_r,  state_nxt;
  logic [CW-1:0] cnt_r,    cnt_nxt;
  logic [CW-1:0] rem_r,    rem_nxt;     // reads still to issue
  logic [AW-1:0] ptr_r,    ptr_nxt;     // next read address
  logic [AW-1:0] rdaddr_r;              // address of the read now in rdata_r
  logic          pend_r,   pend_nxt;    // rdata_r holds a fresh read
  logic [AW-1:0] idx_r,    idx_nxt;     // insert target slot
  val_t          val_r,    val_nxt;

  logic          ovld_r,   ovld_nxt;
  status_t       ost_r,    ost_nxt;
  logic [OUT_W-1:0] ofnd_r, ofnd_nxt;
  val_t          ord_r,    ord_nxt;
  logic [OUT_W-1:0] ocnt_r, ocnt_nxt;

  // Widened views for compares and index arithmetic
  logic [LW-1:0] pos_l, cnt_l, pos_m1_l, cnt_m1_l, cnt_p1_l, fnd_l;
  logic [LW-1:0] ins_mv_l, del_mv_l;
  logic          accept, match;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign pos_l     = LW'(in_position);
  assign cnt_l     = LW'(cnt_r);
  assign pos_m1_l  = pos_l - LW'(1);
  assign cnt_m1_l  = cnt_l - LW'(1);
  assign cnt_p1_l  = cnt_l + LW'(1);
  assign ins_mv_l  = cnt_l - pos_l + LW'(1);
  assign del_mv_l  = cnt_l - pos_l;
  assign fnd_l     = LW'(rdaddr_r) + LW'(1);
  assign match     = pend_r && (rdata_r == val_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    ptr_nxt   = ptr_r;
    idx_nxt   = idx_r;
    val_nxt   = val_r;
    pend_nxt  = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = rdaddr_r;
    mem_wd    = rdata_r;
    mem_re    = 1'b0;
    ovld_nxt  = 1'b0;
    ost_nxt   = ST_OK;
    ofnd_nxt  = '0;
    ord_nxt   = '0;
    ocnt_nxt  = ocnt_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          val_nxt = in_value;
          unique case (in_cmd)
            CMD_CLEAR: begin
              cnt_nxt  = '0;
              ovld_nxt = 1'b1;
            end
            CMD_INSERT: begin
              if (cnt_r == CW'(CAPACITY)) begin
                ost_nxt  = ST_FULL;
                ovld_nxt = 1'b1;
              end else if (pos_l == '0 || pos_l > cnt_p1_l) begin
                ost_nxt  = ST_BADPOS;
                ovld_nxt = 1'b1;
              end else begin
                rem_nxt   = ins_mv_l[CW-1:0];
                ptr_nxt   = cnt_m1_l[AW-1:0];
                idx_nxt   = pos_m1_l[AW-1:0];
                state_nxt = S_INS;
              end
            end
            CMD_DELETE: begin
              if (cnt_r == '0) begin
                ost_nxt  = ST_EMPTY;
                ovld_nxt = 1'b1;
              end else if (pos_l == '0 || pos_l > cnt_l) begin
                ost_nxt  = ST_BADPOS;
                ovld_nxt = 1'b1;
              end else begin
                rem_nxt   = del_mv_l[CW-1:0];
                ptr_nxt   = pos_l[AW-1:0];
                state_nxt = S_DEL;
              end
            end
            CMD_LOCATE: begin
              rem_nxt   = cnt_r;
              ptr_nxt   = '0;
              state_nxt = S_LOC;
            end
            CMD_RETRIEVE: begin
              if (pos_l == '0 || pos_l > cnt_l) begin
                ost_nxt  = ST_BADPOS;
                ovld_nxt = 1'b1;
              end else begin
                ptr_nxt   = pos_m1_l[AW-1:0];
                state_nxt = S_RET;
              end
            end
            default: begin
              ovld_nxt = 1'b1;
            end
          endcase
          ocnt_nxt = OUT_W'(cnt_nxt);
        end
      end

      S_INS: begin
        // read ptr, then write the registered element one slot higher
        if (rem_r != '0) begin
          mem_re   = 1'b1;
          pend_nxt = 1'b1;
          ptr_nxt  = ptr_r - AW'(1);
          rem_nxt  = rem_r - CW'(1);
        end
        if (pend_r) begin
          mem_we = 1'b1;
          mem_wa = rdaddr_r + AW'(1);
        end else if (rem_r == '0) begin
          mem_we    = 1'b1;
          mem_wa    = idx_r;
          mem_wd    = val_r;
          cnt_nxt   = cnt_r + CW'(1);
          ocnt_nxt  = OUT_W'(cnt_nxt);
          ovld_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_DEL: begin
        if (rem_r != '0) begin
          mem_re   = 1'b1;
          pend_nxt = 1'b1;
          ptr_nxt  = ptr_r + AW'(1);
          rem_nxt  = rem_r - CW'(1);
        end
        if (pend_r) begin
          mem_we = 1'b1;
          mem_wa = rdaddr_r - AW'(1);
        end
        if (rem_r == '0 && !pend_r) begin
          cnt_nxt   = cnt_r - CW'(1);
          ocnt_nxt  = OUT_W'(cnt_nxt);
          ovld_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_LOC: begin
        if (match) begin
          ofnd_nxt  = fnd_l[OUT_W-1:0];
          ovld_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else if (rem_r != '0) begin
          mem_re   = 1'b1;
          pend_nxt = 1'b1;
          ptr_nxt  = ptr_r + AW'(1);
          rem_nxt  = rem_r - CW'(1);
        end else if (!pend_r) begin
          ofnd_nxt  = cnt_p1_l[OUT_W-1:0];
          ovld_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_RET: begin
        if (pend_r) begin
          ord_nxt   = rdata_r;
          ovld_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          mem_re   = 1'b1;
          pend_nxt = 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Shifts move away from the read pointer, so a write never hits the entry read in
  // the same cycle: no forwarding needed.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata_r  <= mem[ptr_r];
      rdaddr_r <= ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      rem_r   <= '0;
      pend_r  <= 1'b0;
      ovld_r  <= 1'b0;
      ocnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
      pend_r  <= pend_nxt;
      ovld_r  <= ovld_nxt;
      ocnt_r  <= ocnt_nxt;
    end
  end

  // Payload: no reset
  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    idx_r  <= idx_nxt;
    val_r  <= val_nxt;
    ost_r  <= ost_nxt;
    ofnd_r <= ofnd_nxt;
    ord_r  <= ord_nxt;
  end

  assign out_valid          = ovld_r;
  assign out_status         = ost_r;
  assign out_found_position = ofnd_r;
  assign out_read_value     = ord_r;
  assign out_count          = ocnt_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mem_we)
    else $error("store written while idle");

  a_pend_busy: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r != S_IDLE))
    else $error("read outstanding while idle");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || out_valid))
    else $error("item taken but neither busy nor result");

  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(accept) || $past(busy)))
    else $error("result without an item");

endmodule
